### rtl/u16u8_pkg.sv
// Shared types, constants and the UTF-8 byte formatter for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam int CODE_W     = 16;
  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LIMIT   = 1'd1;

  // Code unit classes
  localparam logic [CODE_W-1:0] HIGH_FIRST   = 16'hD800;
  localparam logic [CODE_W-1:0] HIGH_LAST    = 16'hDBFF;
  localparam logic [CODE_W-1:0] LOW_FIRST    = 16'hDC00;
  localparam logic [CODE_W-1:0] LOW_LAST     = 16'hDFFF;
  localparam logic [CODE_W-1:0] STR_END      = 16'h0000;
  localparam logic [CODE_W-1:0] ONE_BYTE_END = 16'h0080;
  localparam logic [CODE_W-1:0] TWO_BYTE_END = 16'h0800;
  localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h10000;
  localparam logic [CODE_W-1:0] LIMIT_RESET  = 16'hFFFF;

  // Sequence length codes (byte count minus one)
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  // One classified code point waiting for serialization
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      len_m1;
  } cp_entry_t;

  // Byte idx of the UTF-8 sequence of cp
  function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
                                                  input logic [1:0] len_m1,
                                                  input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    case (len_m1)
      LEN_1: b = {1'b0, cp[6:0]};
      LEN_2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      LEN_3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_4: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

### rtl/u16u8_if.sv
// Stream interfaces for the code unit input and the UTF-8 byte output.
`timescale 1ns / 1ps

interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

### rtl/u16u8_front.sv
// Front end: accepts code units, tracks surrogates and budget, queues finished code points.
`timescale 1ns / 1ps

module u16u8_front (
  input  logic                          clk,
  input  logic                          rst_n,
  u16u8_unit_if.sink                    in_unit,
  input  logic                          cfg_we,
  input  logic [u16u8_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [u16u8_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output u16u8_pkg::cp_entry_t          q_entry
);
  import u16u8_pkg::*;

  logic              limit_en_r, limit_en_nxt;
  logic [CODE_W-1:0] unit_limit_r, unit_limit_nxt;
  logic [CODE_W-1:0] units_left_r, units_left_nxt;
  logic              high_pend_r, high_pend_nxt;
  logic [9:0]        high_bits_r, high_bits_nxt;

  logic              accept;
  logic              is_high;
  logic              is_low;
  logic [CODE_W-1:0] unit;

  assign in_unit.ready = !q_full;
  assign accept  = in_unit.valid && !q_full;
  assign unit    = in_unit.code_unit;
  assign is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
  assign is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);

  // Classify the unit, update state and build the queue entry
  always_comb begin
    limit_en_nxt   = limit_en_r;
    unit_limit_nxt = unit_limit_r;
    units_left_nxt = units_left_r;
    high_pend_nxt  = high_pend_r;
    high_bits_nxt  = high_bits_r;
    q_push         = 1'b0;
    q_entry.cp     = {{(CP_W-CODE_W){1'b0}}, unit};
    q_entry.len_m1 = LEN_3;
    if (unit < ONE_BYTE_END) begin
      q_entry.len_m1 = LEN_1;
    end else if (unit < TWO_BYTE_END) begin
      q_entry.len_m1 = LEN_2;
    end

    if (accept) begin
      if (unit == STR_END) begin
        high_pend_nxt  = 1'b0;
        high_bits_nxt  = '0;
        units_left_nxt = unit_limit_r;
      end else if (high_pend_r && is_low) begin
        // join the held high half; the pair was counted with its high
        high_pend_nxt  = 1'b0;
        high_bits_nxt  = '0;
        q_push         = 1'b1;
        q_entry.cp     = SUPP_BASE + {1'b0, high_bits_r, unit[9:0]};
        q_entry.len_m1 = LEN_4;
      end else begin
        // drop any held high half, then charge the budget
        high_pend_nxt = 1'b0;
        high_bits_nxt = '0;
        if (!(limit_en_r && (units_left_r == '0))) begin
          if (limit_en_r) begin
            units_left_nxt = units_left_r - 1'b1;
          end
          if (is_high) begin
            high_pend_nxt = 1'b1;
            high_bits_nxt = unit[9:0];
          end else if (!is_low) begin
            q_push = 1'b1;
          end
        end
      end
    end

    // Register writes
    if (cfg_we) begin
      case (cfg_idx)
        CFG_LIMIT_ENABLE: limit_en_nxt = cfg_data[0];
        CFG_UNIT_LIMIT: begin
          unit_limit_nxt = cfg_data[CODE_W-1:0];
          units_left_nxt = cfg_data[CODE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_en_r   <= 1'b0;
      unit_limit_r <= LIMIT_RESET;
      units_left_r <= LIMIT_RESET;
      high_pend_r  <= 1'b0;
      high_bits_r  <= '0;
    end else begin
      limit_en_r   <= limit_en_nxt;
      unit_limit_r <= unit_limit_nxt;
      units_left_r <= units_left_nxt;
      high_pend_r  <= high_pend_nxt;
      high_bits_r  <= high_bits_nxt;
    end
  end

endmodule

### rtl/u16u8_queue.sv
// Short FIFO of classified code points between the front and back ends.
`timescale 1ns / 1ps

module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u16u8_pkg::cp_entry_t push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output u16u8_pkg::cp_entry_t head_entry
);
  import u16u8_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cp_entry_t         slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/u16u8_back.sv
// Back end: serializes queued code points into UTF-8 beats through an output register.
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  u16u8_pkg::cp_entry_t head_entry,
  output logic                 pop,
  u16u8_byte_if.source         out_bytes
);
  import u16u8_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              last_byte_r, last_byte_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              load;
  logic              is_last;

  assign load    = !out_valid_r || out_bytes.ready;
  assign is_last = (idx_r == head_entry.len_m1);

  assign out_bytes.valid     = out_valid_r;
  assign out_bytes.out_byte  = out_byte_r;
  assign out_bytes.last_byte = last_byte_r;

  // Fill the output register with the next byte of the head entry
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_byte_nxt = last_byte_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_byte_nxt  = utf8_byte(head_entry.cp, head_entry.len_m1, idx_r);
        last_byte_nxt = is_last;
        if (is_last) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    last_byte_r <= last_byte_nxt;
  end

endmodule

### rtl/utf16_to_utf8_transcoder_core.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, code point queue, back end.
//
//   Channel     Dir  Payload                       Beat taken when
//   in_unit     in   code_unit[15:0]               valid && ready
//   out_bytes   out  out_byte[7:0], last_byte      valid && ready
//   cfg_*       in   cfg_idx[0], cfg_data[15:0]    cfg_we high
//
// Flow: a unit is taken whenever the queue has room; the output port sends one
// byte per cycle while out_bytes.ready is high, 1 to 4 bytes per code point by its
// UTF-8 length; units that emit nothing take no output beats.
// An input beat reaches the output through a queue slot and then the output register.
// Reset: synchronous, active low; empties the queue and output register,
// clears the held surrogate and sets the budget and limit to 65535.
// Stalls: the output register and queue let input beats continue while a byte
// waits; in_unit.ready drops only while the queue is full.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  u16u8_unit_if.sink                       in_unit,
  u16u8_byte_if.source                     out_bytes,
  input  logic                             cfg_we,
  input  logic [u16u8_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [u16u8_pkg::CFG_DATA_W-1:0] cfg_data
);
  import u16u8_pkg::*;

  logic      q_full;
  logic      q_push;
  cp_entry_t q_entry;
  logic      q_pop;
  logic      q_head_valid;
  cp_entry_t q_head;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_unit  (in_unit),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_bytes  (out_bytes)
  );

endmodule

### rtl/u16u8_checker.sv
// Port-level checks on UTF-8 sequence framing, bound to the transcoder top level.
`timescale 1ns / 1ps

module u16u8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  logic out_beat;
  logic mid_r, mid_nxt;

  assign out_beat = out_valid && out_ready;

  // Track whether the next beat continues a multibyte sequence
  always_comb begin
    mid_nxt = mid_r;
    if (out_beat) begin
      mid_nxt = !last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
    end
  end

  // A stalled beat keeps valid asserted
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid)
    else $error("out beat withdrawn while stalled");

  // Output register is empty after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // Continuation bytes appear exactly inside a sequence
  a_cont_frame: assert property (@(posedge clk) disable iff (!rst_n)
      out_beat |-> ((out_byte[7:6] == 2'b10) == mid_r))
    else $error("continuation byte out of place");

  // A one-byte sequence is ASCII, a lead byte of a longer one is not
  a_single_ascii: assert property (@(posedge clk) disable iff (!rst_n)
      out_beat && !mid_r |-> (last_byte == !out_byte[7]))
    else $error("lead byte does not match sequence length");

  // Lead bytes are never C0, C1 or F5 and above (overlong two-byte or out-of-range)
  a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_beat && !mid_r |-> !(out_byte == 8'hC0 || out_byte == 8'hC1 ||
                               out_byte >= 8'hF5))
    else $error("illegal lead byte");

endmodule

bind utf16_to_utf8_transcoder_core u16u8_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bytes.valid),
  .out_ready (out_bytes.ready),
  .out_byte  (out_bytes.out_byte),
  .last_byte (out_bytes.last_byte)
);
